### rtl/kme_pkg.sv
`default_nettype none

package kme_pkg;

    localparam int VTX_BITS    = 5;
    localparam int KIND_BITS   = 2;
    localparam int STATUS_BITS = 3;
    localparam int VCOUNT_BITS = 6;

    localparam int DEF_MAX_VERTICES = 32;
    localparam int DEF_MAX_EDGES    = 128;
    localparam int DEF_WEIGHT_BITS  = 16;

    localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = 6'd32;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_ADD,
        KIND_REMOVE,
        KIND_RUN,
        KIND_NOP
    } t_kind;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK,
        ST_BAD_VERTEX,
        ST_SELF_LOOP,
        ST_EXISTS,
        ST_ABSENT,
        ST_FULL,
        ST_TOO_FEW,
        ST_TREE
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_SCAN,
        S_REM_SCAN,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RUN_SCAN,
        S_RUN_PICK,
        S_LEAD_HI,
        S_MERGE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic    accept;
        logic    scan_start;
        logic    scan_en;
        logic    set_res;
        t_status res_code;
        logic    res_edge;
        logic    res_last;
        logic    out_load;
        logic    append;
        logic    shift_rd;
        logic    shift_wr;
        logic    dec_total;
        logic    run_init;
        logic    take_best;
        logic    rd_lead_lo;
        logic    rd_lead_hi;
        logic    merge;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  bad;
        logic  self_loop;
        logic  too_few;
        logic  full;
        logic  scan_done;
        logic  found;
        logic  best_valid;
        logic  same_set;
        logic  k_full;
        logic  shift_more;
        logic  out_free;
        logic  res_last;
    } t_stat;

endpackage

`default_nettype wire

### rtl/kme_ctrl.sv
`default_nettype none

module kme_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  kme_pkg::t_stat i_stat,
    output kme_pkg::t_cmd  o_cmd,
    output logic          o_busy
);
    import kme_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (i_stat.kind)
                    KIND_ADD: begin
                        if (i_stat.bad || i_stat.self_loop) n_state = S_EMIT;
                        else n_state = S_ADD_SCAN;
                    end
                    KIND_REMOVE: begin
                        if (i_stat.bad) n_state = S_EMIT;
                        else n_state = S_REM_SCAN;
                    end
                    KIND_RUN: begin
                        if (i_stat.too_few) n_state = S_EMIT;
                        else n_state = S_RUN_SCAN;
                    end
                    default: n_state = S_EMIT;
                endcase
            end
            S_ADD_SCAN: begin
                if (i_stat.scan_done) n_state = S_EMIT;
            end
            S_REM_SCAN: begin
                if (i_stat.scan_done) begin
                    if (i_stat.found) n_state = S_SHIFT_RD;
                    else n_state = S_EMIT;
                end
            end
            S_SHIFT_RD: begin
                if (i_stat.shift_more) n_state = S_SHIFT_WR;
                else n_state = S_EMIT;
            end
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_RUN_SCAN: begin
                if (i_stat.scan_done) n_state = S_RUN_PICK;
            end
            S_RUN_PICK: begin
                if (i_stat.k_full || !i_stat.best_valid) n_state = S_EMIT;
                else n_state = S_LEAD_HI;
            end
            S_LEAD_HI: n_state = S_MERGE;
            S_MERGE: begin
                if (i_stat.same_set) n_state = S_RUN_SCAN;
                else n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    if (i_stat.res_last) n_state = S_IDLE;
                    else n_state = S_RUN_SCAN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.res_code = ST_OK;
        o_cmd.res_last = 1'b1;
        unique case (r_state)
            S_IDLE: o_cmd.accept = i_in_valid;
            S_DECODE: begin
                unique case (i_stat.kind)
                    KIND_ADD: begin
                        if (i_stat.bad) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_code = ST_BAD_VERTEX;
                        end else if (i_stat.self_loop) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_code = ST_SELF_LOOP;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                        end
                    end
                    KIND_REMOVE: begin
                        if (i_stat.bad) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_code = ST_BAD_VERTEX;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                        end
                    end
                    KIND_RUN: begin
                        if (i_stat.too_few) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_code = ST_TOO_FEW;
                        end else begin
                            o_cmd.run_init   = 1'b1;
                            o_cmd.scan_start = 1'b1;
                        end
                    end
                    default: o_cmd.set_res = 1'b1;
                endcase
            end
            S_ADD_SCAN: begin
                if (!i_stat.scan_done) begin
                    o_cmd.scan_en = 1'b1;
                end else if (i_stat.found) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_EXISTS;
                end else if (i_stat.full) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_FULL;
                end else begin
                    o_cmd.append  = 1'b1;
                    o_cmd.set_res = 1'b1;
                end
            end
            S_REM_SCAN: begin
                if (!i_stat.scan_done) begin
                    o_cmd.scan_en = 1'b1;
                end else if (!i_stat.found) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_ABSENT;
                end
            end
            S_SHIFT_RD: begin
                if (i_stat.shift_more) begin
                    o_cmd.shift_rd = 1'b1;
                end else begin
                    o_cmd.dec_total = 1'b1;
                    o_cmd.set_res   = 1'b1;
                end
            end
            S_SHIFT_WR: o_cmd.shift_wr = 1'b1;
            S_RUN_SCAN: o_cmd.scan_en = !i_stat.scan_done;
            S_RUN_PICK: begin
                if (i_stat.k_full || !i_stat.best_valid) begin
                    o_cmd.set_res = 1'b1;
                end else begin
                    o_cmd.take_best  = 1'b1;
                    o_cmd.rd_lead_lo = 1'b1;
                end
            end
            S_LEAD_HI: o_cmd.rd_lead_hi = 1'b1;
            S_MERGE: begin
                if (i_stat.same_set) begin
                    o_cmd.scan_start = 1'b1;
                end else begin
                    o_cmd.merge    = 1'b1;
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_TREE;
                    o_cmd.res_edge = 1'b1;
                    o_cmd.res_last = 1'b0;
                end
            end
            S_EMIT: begin
                o_cmd.out_load   = i_stat.out_free;
                o_cmd.scan_start = i_stat.out_free && !i_stat.res_last;
            end
            default: o_cmd.accept = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/kme_dp.sv
`default_nettype none

module kme_dp #(
    parameter int MAX_VERTICES = kme_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = kme_pkg::DEF_MAX_EDGES,
    parameter int WEIGHT_BITS  = kme_pkg::DEF_WEIGHT_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [kme_pkg::VCOUNT_BITS-1:0]  i_cfg_wdata,
    input  logic [kme_pkg::KIND_BITS-1:0]    i_kind,
    input  logic [kme_pkg::VTX_BITS-1:0]     i_src,
    input  logic [kme_pkg::VTX_BITS-1:0]     i_dest,
    input  logic signed [WEIGHT_BITS-1:0]    i_weight,
    input  kme_pkg::t_cmd                    i_cmd,
    output kme_pkg::t_stat                   o_stat,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic [kme_pkg::STATUS_BITS-1:0]  o_status,
    output logic [kme_pkg::VTX_BITS-1:0]     o_edge_low,
    output logic [kme_pkg::VTX_BITS-1:0]     o_edge_high,
    output logic signed [WEIGHT_BITS-1:0]    o_edge_weight,
    output logic                             o_last
);
    import kme_pkg::*;

    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW  = $clog2(MAX_EDGES + 1);
    localparam int LW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NVW = VCOUNT_BITS + 1;

    typedef struct packed {
        logic [VTX_BITS-1:0]          lo;
        logic [VTX_BITS-1:0]          hi;
        logic signed [WEIGHT_BITS-1:0] w;
    } t_edge;

    // true when edge a is taken before edge b
    function automatic logic precedes(t_edge a, logic [EW-1:0] ia, t_edge b, logic [EW-1:0] ib);
        logic res;
        if (a.w != b.w) res = (a.w < b.w);
        else if (a.lo != b.lo) res = (a.lo < b.lo);
        else res = (ia > ib);
        return res;
    endfunction

    logic [VCOUNT_BITS-1:0] r_vcount;
    logic [CW-1:0]          r_total;
    t_kind                  r_kind;
    t_edge                  r_item;

    t_edge                  mem [MAX_EDGES];
    t_edge                  r_rd_data;

    logic [CW-1:0]          r_idx;
    logic                   r_pend;
    logic [EW-1:0]          r_pend_idx;
    logic                   r_found;
    logic [EW-1:0]          r_pos;

    t_edge                  r_best;
    logic [EW-1:0]          r_best_idx;
    logic                   r_best_valid;
    t_edge                  r_last;
    logic [EW-1:0]          r_last_idx;
    logic                   r_last_valid;

    logic [LW-1:0]          r_lead [MAX_VERTICES];
    logic [LW-1:0]          r_a;
    logic [LW-1:0]          r_b;
    logic [LW-1:0]          r_k;

    t_status                r_res_code;
    logic                   r_res_edge;
    logic                   r_res_last;

    logic                   r_o_valid;
    t_status                r_o_status;
    logic [VTX_BITS-1:0]    r_o_low;
    logic [VTX_BITS-1:0]    r_o_high;
    logic signed [WEIGHT_BITS-1:0] r_o_weight;
    logic                   r_o_last;

    logic [NVW-1:0]         nv;
    logic [NVW-1:0]         need;
    logic                   scan_issue;
    logic [CW-1:0]          pos_next;
    logic [EW-1:0]          rd_addr;
    logic                   wr_en;
    logic [EW-1:0]          wr_addr;
    t_edge                  wr_data;
    logic                   match;
    logic                   pick;
    logic [VTX_BITS-1:0]    lead_vtx;
    logic [LW-1:0]          lead_rd;
    logic                   out_free;
    t_edge                  in_edge;

    // effective vertex count and run threshold
    always_comb begin
        if ({1'b0, r_vcount} > NVW'(MAX_VERTICES)) nv = NVW'(MAX_VERTICES);
        else nv = {1'b0, r_vcount};
        need = (nv == '0) ? '0 : nv - NVW'(1);
    end

    always_comb begin
        in_edge.lo = (i_src < i_dest) ? i_src : i_dest;
        in_edge.hi = (i_src < i_dest) ? i_dest : i_src;
        in_edge.w  = i_weight;
    end

    assign scan_issue = i_cmd.scan_en && (r_idx < r_total);
    assign pos_next   = CW'(r_pos) + CW'(1);
    assign rd_addr    = i_cmd.shift_rd ? pos_next[EW-1:0] : r_idx[EW-1:0];
    assign wr_en      = i_cmd.append || i_cmd.shift_wr;
    assign wr_addr    = i_cmd.append ? r_total[EW-1:0] : r_pos;
    assign wr_data    = i_cmd.append ? r_item : r_rd_data;
    assign match      = (r_rd_data.lo == r_item.lo) && (r_rd_data.hi == r_item.hi);
    assign pick       = (!r_last_valid || precedes(r_last, r_last_idx, r_rd_data, r_pend_idx))
                     && (!r_best_valid || precedes(r_rd_data, r_pend_idx, r_best, r_best_idx));
    assign lead_vtx   = i_cmd.rd_lead_hi ? r_best.hi : r_best.lo;
    assign lead_rd    = r_lead[LW'(lead_vtx)];
    assign out_free   = !r_o_valid || !i_out_stall;

    always_comb begin
        o_stat.kind       = r_kind;
        o_stat.bad        = (NVW'(r_item.hi) >= nv);
        o_stat.self_loop  = (r_item.lo == r_item.hi);
        o_stat.too_few    = (32'(r_total) < 32'(need));
        o_stat.full       = (r_total == CW'(MAX_EDGES));
        o_stat.scan_done  = (r_idx >= r_total) && !r_pend;
        o_stat.found      = r_found;
        o_stat.best_valid = r_best_valid;
        o_stat.same_set   = (r_a == r_b);
        o_stat.k_full     = (r_k == LW'(MAX_VERTICES - 1));
        o_stat.shift_more = (pos_next < r_total);
        o_stat.out_free   = out_free;
        o_stat.res_last   = r_res_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCOUNT_RESET;
            r_total  <= '0;
            r_pend   <= 1'b0;
        end else begin
            if (i_cfg_we) r_vcount <= i_cfg_wdata;
            if (i_cmd.append) r_total <= r_total + CW'(1);
            else if (i_cmd.dec_total) r_total <= r_total - CW'(1);
            r_pend <= !i_cmd.scan_start && scan_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= t_kind'(i_kind);
            r_item <= in_edge;
        end
    end

    // edge store
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rd_data <= mem[rd_addr];
    end

    // store walk: duplicate search and ordered selection
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_idx        <= '0;
            r_found      <= 1'b0;
            r_best_valid <= 1'b0;
        end else begin
            if (scan_issue) begin
                r_idx      <= r_idx + CW'(1);
                r_pend_idx <= r_idx[EW-1:0];
            end
            if (r_pend && match) r_found <= 1'b1;
            if (r_pend && pick) begin
                r_best       <= r_rd_data;
                r_best_idx   <= r_pend_idx;
                r_best_valid <= 1'b1;
            end
        end
        if (i_cmd.shift_wr) r_pos <= r_pos + EW'(1);
        else if (r_pend && match && !i_cmd.scan_start) r_pos <= r_pend_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.run_init) r_last_valid <= 1'b0;
        else if (i_cmd.take_best) r_last_valid <= 1'b1;
        if (i_cmd.take_best) begin
            r_last     <= r_best;
            r_last_idx <= r_best_idx;
        end
    end

    // vertex set labels
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_VERTICES; j++) begin
            if (i_cmd.run_init) r_lead[j] <= LW'(j);
            else if (i_cmd.merge && (r_lead[j] == r_b)) r_lead[j] <= r_a;
        end
        if (i_cmd.rd_lead_lo) r_a <= lead_rd;
        if (i_cmd.rd_lead_hi) r_b <= lead_rd;
        if (i_cmd.run_init) r_k <= '0;
        else if (i_cmd.merge) r_k <= r_k + LW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            r_res_code <= i_cmd.res_code;
            r_res_edge <= i_cmd.res_edge;
            r_res_last <= i_cmd.res_last;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_res_code;
            r_o_last   <= r_res_last;
            r_o_low    <= r_res_edge ? r_best.lo : '0;
            r_o_high   <= r_res_edge ? r_best.hi : '0;
            r_o_weight <= r_res_edge ? r_best.w : '0;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_status      = r_o_status;
    assign o_edge_low    = r_o_low;
    assign o_edge_high   = r_o_high;
    assign o_edge_weight = r_o_weight;
    assign o_last        = r_o_last;

endmodule

`default_nettype wire

### rtl/kruskal_mst_engine.sv
// add: one store walk for duplicates
// remove: as add when absent; on a hit each later entry moves down the store, read then write
// run: per edge considered a store walk and pick and a lookup of both endpoint sets, plus an
//   emit per tree edge; one store read port
// one item in flight; the next is taken once all its results are in the output register
// reset: synchronous, edge store empty, vertex_count 32, no clearing pass
`default_nettype none

module kruskal_mst_engine #(
    parameter int MAX_VERTICES = kme_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = kme_pkg::DEF_MAX_EDGES,
    parameter int WEIGHT_BITS  = kme_pkg::DEF_WEIGHT_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [kme_pkg::VCOUNT_BITS-1:0]  i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [kme_pkg::KIND_BITS-1:0]    i_kind,
    input  logic [kme_pkg::VTX_BITS-1:0]     i_src,
    input  logic [kme_pkg::VTX_BITS-1:0]     i_dest,
    input  logic signed [WEIGHT_BITS-1:0]    i_weight,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [kme_pkg::STATUS_BITS-1:0]  o_status,
    output logic [kme_pkg::VTX_BITS-1:0]     o_edge_low,
    output logic [kme_pkg::VTX_BITS-1:0]     o_edge_high,
    output logic signed [WEIGHT_BITS-1:0]    o_edge_weight,
    output logic                             o_last
);
    import kme_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    kme_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (o_in_stall)
    );

    kme_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_kind        (i_kind),
        .i_src         (i_src),
        .i_dest        (i_dest),
        .i_weight      (i_weight),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_edge_low    (o_edge_low),
        .o_edge_high   (o_edge_high),
        .o_edge_weight (o_edge_weight),
        .o_last        (o_last)
    );

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is in progress");

    a_only_tree_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_status == ST_TREE))
        else $error("non-final result that is not a tree edge");

    a_plain_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_TREE)) |->
        (o_edge_low == '0 && o_edge_high == '0 && o_edge_weight == '0))
        else $error("edge fields set on a status result");

    a_tree_edge_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_TREE)) |-> (o_edge_low < o_edge_high))
        else $error("tree edge endpoints out of order");

endmodule

`default_nettype wire
